>>> rtl/cmpb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the cascaded motor pid bank
// no dependencies

package cmpb_pkg;

  localparam int MOTORS     = 8;
  localparam int MOTOR_W    = 3;
  localparam int ANGLE_BITS = 13;
  localparam int INTEG_W    = 32;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;

  // command codes of an input transaction
  localparam logic [1:0] CMD_FEEDBACK = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_TARGET   = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_CASCADE = 3'd0;
  localparam logic [2:0] REG_AGAINS  = 3'd1;
  localparam logic [2:0] REG_SGAINS  = 3'd2;
  localparam logic [2:0] REG_ALIMITS = 3'd3;
  localparam logic [2:0] REG_SLIMITS = 3'd4;
  localparam logic [2:0] REG_CURLIM  = 3'd5;
  localparam logic [2:0] REG_WRAP    = 3'd6;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [MOTOR_W-1:0]      motor;
    logic [ANGLE_BITS-1:0]   angle;
    logic signed [15:0]      speed;
    logic signed [31:0]      tgt_angle;
    logic signed [15:0]      tgt_speed;
    logic [15:0]             etime;
  } item_t;

  typedef struct packed {
    logic        cascade;
    logic [47:0] angle_gains;
    logic [47:0] speed_gains;
    logic [63:0] angle_limits;
    logic [47:0] speed_limits;
    logic [14:0] current_limit;
    logic [12:0] wrap_threshold;
  } cfg_t;

endpackage

>>> rtl/cmpb_front.sv
`timescale 1ns / 1ps
// front end: accepts input transactions, drops unknown commands and
// queues the rest for the back end; depends on cmpb_pkg

module cmpb_front import cmpb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  item_t                 item_i,
  output logic                  item_valid_o,
  output item_t                 item_o,
  input  logic                  item_pop_i
);

  item_t       slot_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  count_q, count_d;
  logic        accept, enq, deq;

  // classify: unknown commands are taken but not queued
  assign full_o       = (count_q == 2'd2);
  assign accept       = push_i && !full_o;
  assign enq          = accept && (item_i.cmd != CMD_NONE);
  assign deq          = item_pop_i && (count_q != 2'd0);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_q];

  always_comb begin
    wr_d    = wr_q ^ enq;
    rd_d    = rd_q ^ deq;
    count_d = count_q + {1'b0, enq} - {1'b0, deq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("front queue count out of range");
`endif

endmodule

>>> rtl/cmpb_div.sv
`timescale 1ns / 1ps
// radix-2 restoring divider, one quotient bit per cycle, signed result
// no package dependencies

module cmpb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        dvd_i,
  input  logic [15:0]        dvs_i,
  input  logic               neg_i,
  output logic               busy_o,
  output logic signed [32:0] quo_o
);

  logic [16:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [15:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic        busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [16:0] trial;

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  // one shift and subtract step
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    trial  = {rem_q[15:0], quo_q[31]};
    if (start_i) begin
      rem_d  = 17'd0;
      quo_d  = dvd_i;
      dvs_d  = dvs_i;
      neg_d  = neg_i;
      busy_d = 1'b1;
      cnt_d  = 5'd0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

endmodule

>>> rtl/cmpb_core.sv
`timescale 1ns / 1ps
// back end: per-motor state, shared multiplier sequencer for both pid loops
// and the result register; depends on cmpb_pkg and cmpb_div

module cmpb_core import cmpb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  item_valid_i,
  input  item_t                 item_i,
  output logic                  item_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [MOTOR_W-1:0]    out_motor_o,
  output logic signed [15:0]    current_code_o,
  output logic                  last_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_FB_ANG = 4'd1;
  localparam logic [3:0] ST_ERR    = 4'd2;
  localparam logic [3:0] ST_MSTEP  = 4'd3;
  localparam logic [3:0] ST_MDEC   = 4'd4;
  localparam logic [3:0] ST_INT    = 4'd5;
  localparam logic [3:0] ST_MP     = 4'd6;
  localparam logic [3:0] ST_MI     = 4'd7;
  localparam logic [3:0] ST_ADDI   = 4'd8;
  localparam logic [3:0] ST_WDIV   = 4'd9;
  localparam logic [3:0] ST_MD     = 4'd10;
  localparam logic [3:0] ST_SUM    = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;

  // saturate a wide signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
    if (v > 52'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -52'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  // clamp a signed value to +-lim
  function automatic logic signed [16:0] clamp16(input logic signed [33:0] v,
                                                 input logic [15:0] lim);
    logic signed [33:0] l;
    l = $signed({18'd0, lim});
    if (v > l) begin
      clamp16 = l[16:0];
    end else if (v < -l) begin
      clamp16 = 17'(-l);
    end else begin
      clamp16 = v[16:0];
    end
  endfunction

  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    mag17 = v[16] ? 17'(-v) : 17'(v);
  endfunction

  // per-motor state
  logic [15:0]        lap_q   [MOTORS], lap_d   [MOTORS];
  logic [12:0]        fa_q    [MOTORS], fa_d    [MOTORS];
  logic signed [15:0] fs_q    [MOTORS], fs_d    [MOTORS];
  logic signed [31:0] ga_q    [MOTORS], ga_d    [MOTORS];
  logic signed [15:0] gs_q    [MOTORS], gs_d    [MOTORS];
  logic signed [31:0] aint_q  [MOTORS], aint_d  [MOTORS];
  logic signed [31:0] sint_q  [MOTORS], sint_d  [MOTORS];
  logic [31:0]        ahist_q [MOTORS], ahist_d [MOTORS];
  logic [31:0]        shist_q [MOTORS], shist_d [MOTORS];

  // sequencer and datapath registers
  logic [3:0]          state_q, state_d;
  item_t               cur_q, cur_d;
  logic [MOTOR_W-1:0]  k_q, k_d;
  logic                aloop_q, aloop_d;
  logic signed [16:0]  err_q, err_d;
  logic signed [24:0]  step_q, step_d;
  logic signed [50:0]  prod_q, prod_d;
  logic signed [51:0]  acc_q, acc_d;
  logic signed [31:0]  v_q, v_d;
  logic                out_valid_q, out_valid_d;
  logic [MOTOR_W-1:0]  out_motor_q, out_motor_d;
  logic signed [15:0]  out_code_q, out_code_d;
  logic                out_last_q, out_last_d;

  logic [MOTOR_W-1:0]  idx;
  logic [47:0]         gains;
  logic [15:0]         istart, iclamp;
  logic [31:0]         hist;
  logic signed [31:0]  integ;
  logic signed [28:0]  pos;
  logic signed [16:0]  diff;
  logic [16:0]         dmag, emag;
  logic [32:0]         vmag;
  logic [23:0]         lim;
  logic signed [33:0]  isum;
  logic signed [31:0]  dec, vnew;
  logic signed [33:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [50:0]  mul_p;
  logic                div_start, div_busy;
  logic signed [32:0]  div_quo, rate;
  logic signed [13:0]  jump;
  logic signed [16:0]  e17;
  logic signed [43:0]  ushift, clim;
  logic signed [15:0]  code;
  logic                out_free;

  // loop operand selection
  always_comb begin
    if (state_q == ST_IDLE) begin
      idx = item_i.motor;
    end else if (state_q == ST_FB_ANG) begin
      idx = cur_q.motor;
    end else begin
      idx = k_q;
    end
    gains  = aloop_q ? cfg_i.angle_gains : cfg_i.speed_gains;
    istart = aloop_q ? cfg_i.angle_limits[31:16] : cfg_i.speed_limits[31:16];
    iclamp = aloop_q ? cfg_i.angle_limits[47:32] : cfg_i.speed_limits[47:32];
    hist   = aloop_q ? ahist_q[idx] : shist_q[idx];
    integ  = aloop_q ? aint_q[idx] : sint_q[idx];
    pos    = $signed({lap_q[idx], fa_q[idx]});
    diff   = 17'($signed(hist[15:0])) - 17'($signed(hist[31:16]));
    dmag   = mag17(diff);
    emag   = mag17(err_q);
    vmag   = integ[31] ? 33'(-34'(integ)) : 33'(integ);
    lim    = {iclamp, 8'd0};
    rate   = (cur_q.etime == 16'd0) ? 33'sd0 : div_quo;
  end

  // integral update
  always_comb begin
    dec  = integ[31] ? -$signed(prod_q[47:16]) : $signed(prod_q[47:16]);
    isum = 34'(integ) + 34'(step_q);
    if (emag >= {1'b0, istart}) begin
      vnew = aloop_q ? 32'sd0 : dec;
    end else if ({1'b0, vmag} <= {10'd0, lim}) begin
      if (isum > $signed({10'd0, lim})) begin
        vnew = $signed({8'd0, lim});
      end else if (isum < -$signed({10'd0, lim})) begin
        vnew = 32'(-$signed({10'd0, lim}));
      end else begin
        vnew = isum[31:0];
      end
    end else begin
      vnew = integ;
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = 34'(err_q);
    mul_b = $signed({1'b0, cur_q.etime});
    case (state_q)
      ST_MDEC: begin
        mul_a = $signed({1'b0, vmag});
        mul_b = 17'sd26214;
      end
      ST_MP: begin
        mul_b = 17'($signed(gains[15:0]));
      end
      ST_MI: begin
        mul_a = 34'(v_q);
        mul_b = 17'($signed(gains[31:16]));
      end
      ST_MD: begin
        mul_a = 34'(rate);
        mul_b = 17'($signed(gains[47:32]));
      end
      default: begin
      end
    endcase
    mul_p = 51'(mul_a * mul_b);
  end

  assign div_start = (state_q == ST_ERR) && (cur_q.etime != 16'd0);

  cmpb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dvd_i  ({dmag[15:0], 16'd0}),
    .dvs_i  (cur_q.etime),
    .neg_i  (diff[16]),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // current code from the speed loop sum
  always_comb begin
    ushift = 44'(acc_q >>> 8);
    clim   = $signed({29'd0, cfg_i.current_limit});
    if (ushift > clim) begin
      code = clim[15:0];
    end else if (ushift < -clim) begin
      code = 16'(-clim);
    end else begin
      code = ushift[15:0];
    end
  end

  assign out_free   = !out_valid_q || pop_i;
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign jump       = $signed({1'b0, fa_q[idx]}) - $signed({1'b0, item_i.angle});
  assign e17        = 17'(gs_q[idx]) - 17'(fs_q[idx]);

  // sequencer
  always_comb begin
    lap_d   = lap_q;
    fa_d    = fa_q;
    fs_d    = fs_q;
    ga_d    = ga_q;
    gs_d    = gs_q;
    aint_d  = aint_q;
    sint_d  = sint_q;
    ahist_d = ahist_q;
    shist_d = shist_q;
    state_d = state_q;
    cur_d   = cur_q;
    k_d     = k_q;
    aloop_d = aloop_q;
    err_d   = err_q;
    step_d  = step_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    v_d     = v_q;
    out_valid_d = out_valid_q && !pop_i;
    out_motor_d = out_motor_q;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          cur_d = item_i;
          case (item_i.cmd)
            CMD_FEEDBACK: begin
              if ($unsigned(mag17(17'(jump))) >= {4'd0, cfg_i.wrap_threshold}) begin
                lap_d[idx] = (fa_q[idx] > item_i.angle) ? lap_q[idx] + 16'd1
                                                        : lap_q[idx] - 16'd1;
              end
              fa_d[idx] = item_i.angle;
              fs_d[idx] = item_i.speed;
              shist_d[idx] = {shist_q[idx][15:0],
                              sat16(52'(17'(gs_q[idx]) - 17'(item_i.speed)))};
              if (cfg_i.cascade) begin
                state_d = ST_FB_ANG;
              end
            end
            CMD_TARGET: begin
              ga_d[idx] = item_i.tgt_angle;
              gs_d[idx] = item_i.tgt_speed;
            end
            CMD_TICK: begin
              k_d     = '0;
              aloop_d = cfg_i.cascade;
              state_d = ST_ERR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FB_ANG: begin
        ahist_d[idx] = {ahist_q[idx][15:0],
                        sat16(52'(clamp16(34'(ga_q[idx]) - 34'(pos),
                                          cfg_i.angle_limits[63:48])))};
        state_d = ST_IDLE;
      end
      ST_ERR: begin
        if (aloop_q) begin
          err_d = clamp16(34'(ga_q[idx]) - 34'(pos), cfg_i.angle_limits[15:0]);
        end else if (mag17(e17) < {1'b0, cfg_i.speed_limits[15:0]}) begin
          err_d = 17'sd0;
        end else begin
          err_d = e17;
        end
        state_d = ST_MSTEP;
      end
      ST_MSTEP: begin
        prod_d  = mul_p;
        state_d = ST_MDEC;
      end
      ST_MDEC: begin
        step_d  = 25'(prod_q >>> 8);
        prod_d  = mul_p;
        state_d = ST_INT;
      end
      ST_INT: begin
        if (aloop_q) begin
          aint_d[idx] = vnew;
        end else begin
          sint_d[idx] = vnew;
        end
        v_d     = vnew;
        state_d = ST_MP;
      end
      ST_MP: begin
        prod_d  = mul_p;
        state_d = ST_MI;
      end
      ST_MI: begin
        acc_d   = 52'(prod_q);
        prod_d  = mul_p;
        state_d = ST_ADDI;
      end
      ST_ADDI: begin
        acc_d   = acc_q + 52'(prod_q >>> 8);
        state_d = ST_WDIV;
      end
      ST_WDIV: begin
        if (!div_busy) begin
          state_d = ST_MD;
        end
      end
      ST_MD: begin
        prod_d  = mul_p;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        acc_d   = acc_q + 52'(prod_q);
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (aloop_q) begin
          gs_d[idx] = sat16(acc_q >>> 8);
          aloop_d   = 1'b0;
          state_d   = ST_ERR;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_motor_d = k_q;
          out_code_d  = code;
          out_last_d  = (k_q == MOTOR_W'(MOTORS - 1));
          if (k_q == MOTOR_W'(MOTORS - 1)) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + MOTOR_W'(1);
            aloop_d = cfg_i.cascade;
            state_d = ST_ERR;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      aloop_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MOTORS; i++) begin
        lap_q[i]   <= '0;
        fa_q[i]    <= '0;
        fs_q[i]    <= '0;
        ga_q[i]    <= '0;
        gs_q[i]    <= '0;
        aint_q[i]  <= '0;
        sint_q[i]  <= '0;
        ahist_q[i] <= '0;
        shist_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      aloop_q     <= aloop_d;
      out_valid_q <= out_valid_d;
      lap_q       <= lap_d;
      fa_q        <= fa_d;
      fs_q        <= fs_d;
      ga_q        <= ga_d;
      gs_q        <= gs_d;
      aint_q      <= aint_d;
      sint_q      <= sint_d;
      ahist_q     <= ahist_d;
      shist_q     <= shist_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    err_q       <= err_d;
    step_q      <= step_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    v_q         <= v_d;
    out_motor_q <= out_motor_d;
    out_code_q  <= out_code_d;
    out_last_q  <= out_last_d;
  end

  assign empty_o        = !out_valid_q;
  assign out_motor_o    = out_motor_q;
  assign current_code_o = out_code_q;
  assign last_o         = out_last_q;

`ifndef SYNTHESIS
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MD |-> !div_busy) else $error("derivative used before divide done");
  a_last_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_motor_q == MOTOR_W'(MOTORS - 1))
    else $error("last flag on wrong motor");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> $stable(out_code_q) && $stable(out_motor_q))
    else $error("waiting result overwritten");
`endif

endmodule

>>> rtl/cascaded_motor_pid_bank.sv
`timescale 1ns / 1ps
// Cascaded position/velocity PID bank for eight motors.
// Input channel: push/full queue carrying command, motor_index, raw_angle,
// raw_speed, target_angle, target_speed and elapsed_time. A feedback
// transaction updates laps, angle, speed and error histories; a target
// transaction sets goals; a tick runs all motors and yields eight results.
// Result channel: empty/pop queue carrying out_motor, current_code, last.
// In cascade mode a feedback transaction also passes through ST_FB_ANG. A tick
// evaluates each motor's loops in turn; the derivative rate comes from the
// 32-step radix-2 divider (not started when the elapsed time is zero), and in
// cascade mode the angle loop runs before the speed loop, with one loop
// evaluation in flight at a time.
// A two-entry front queue keeps taking transactions while the back end works;
// when the receiver stalls the result register holds and the back end waits.
// Reset clears all motor state and loads the register defaults (current limit
// 16384, wrap threshold 4096); the block is ready right after reset.
// Configuration goes through the APB port at byte address 8*index.
// depends on cmpb_pkg, cmpb_front, cmpb_div, cmpb_core

module cascaded_motor_pid_bank import cmpb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            command_i,
  input  logic [MOTOR_W-1:0]    motor_index_i,
  input  logic [12:0]           raw_angle_i,
  input  logic signed [15:0]    raw_speed_i,
  input  logic signed [31:0]    target_angle_i,
  input  logic signed [15:0]    target_speed_i,
  input  logic [15:0]           elapsed_time_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [MOTOR_W-1:0]    out_motor_o,
  output logic signed [15:0]    current_code_o,
  output logic                  last_o
);

  cfg_t   cfg_q, cfg_d;
  item_t  in_item, q_item;
  logic   q_valid, q_pop;
  logic   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[5:3])
        REG_CASCADE: cfg_d.cascade        = pwdata[0];
        REG_AGAINS:  cfg_d.angle_gains    = pwdata[47:0];
        REG_SGAINS:  cfg_d.speed_gains    = pwdata[47:0];
        REG_ALIMITS: cfg_d.angle_limits   = pwdata;
        REG_SLIMITS: cfg_d.speed_limits   = pwdata[47:0];
        REG_CURLIM:  cfg_d.current_limit  = pwdata[14:0];
        REG_WRAP:    cfg_d.wrap_threshold = pwdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[5:3])
      REG_CASCADE: prdata = 64'(cfg_q.cascade);
      REG_AGAINS:  prdata = 64'(cfg_q.angle_gains);
      REG_SGAINS:  prdata = 64'(cfg_q.speed_gains);
      REG_ALIMITS: prdata = cfg_q.angle_limits;
      REG_SLIMITS: prdata = 64'(cfg_q.speed_limits);
      REG_CURLIM:  prdata = 64'(cfg_q.current_limit);
      REG_WRAP:    prdata = 64'(cfg_q.wrap_threshold);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cascade: 1'b0, angle_gains: '0, speed_gains: '0, angle_limits: '0,
                 speed_limits: '0, current_limit: 15'd16384, wrap_threshold: 13'd4096};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input transaction bundle
  always_comb begin
    in_item.cmd       = command_i;
    in_item.motor     = motor_index_i;
    in_item.angle     = raw_angle_i;
    in_item.speed     = raw_speed_i;
    in_item.tgt_angle = target_angle_i;
    in_item.tgt_speed = target_speed_i;
    in_item.etime     = elapsed_time_i;
  end

  cmpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item),
    .item_valid_o(q_valid),
    .item_o      (q_item),
    .item_pop_i  (q_pop)
  );

  cmpb_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_valid_i  (q_valid),
    .item_i        (q_item),
    .item_pop_o    (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_motor_o   (out_motor_o),
    .current_code_o(current_code_o),
    .last_o        (last_o)
  );

endmodule
